@@ sv/ebalu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared types and operation codes for the 8-bit accumulator ALU with flags.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  // Operation codes carried in the kind field
  localparam logic [4:0] KIND_ADD   = 5'd0;
  localparam logic [4:0] KIND_ADC   = 5'd1;
  localparam logic [4:0] KIND_SUB   = 5'd2;
  localparam logic [4:0] KIND_SBC   = 5'd3;
  localparam logic [4:0] KIND_AND   = 5'd4;
  localparam logic [4:0] KIND_OR    = 5'd5;
  localparam logic [4:0] KIND_XOR   = 5'd6;
  localparam logic [4:0] KIND_CP    = 5'd7;
  localparam logic [4:0] KIND_INC   = 5'd8;
  localparam logic [4:0] KIND_DEC   = 5'd9;
  localparam logic [4:0] KIND_DAA   = 5'd10;
  localparam logic [4:0] KIND_CPL   = 5'd11;
  localparam logic [4:0] KIND_CCF   = 5'd12;
  localparam logic [4:0] KIND_SCF   = 5'd13;
  localparam logic [4:0] KIND_RLC   = 5'd14;
  localparam logic [4:0] KIND_RL    = 5'd15;
  localparam logic [4:0] KIND_RRC   = 5'd16;
  localparam logic [4:0] KIND_RR    = 5'd17;
  localparam logic [4:0] KIND_SLA   = 5'd18;
  localparam logic [4:0] KIND_SRA   = 5'd19;
  localparam logic [4:0] KIND_SRL   = 5'd20;
  localparam logic [4:0] KIND_SWAP  = 5'd21;
  localparam logic [4:0] KIND_BIT   = 5'd22;
  localparam logic [4:0] KIND_SET   = 5'd23;
  localparam logic [4:0] KIND_RES   = 5'd24;
  localparam logic [4:0] KIND_ADDW  = 5'd25;
  localparam logic [4:0] KIND_ADDSP = 5'd26;

  // Power-up state
  localparam logic [7:0] ACC_RESET = 8'h01;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'd9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{z: 1'b1, n: 1'b0, h: 1'b1, c: 1'b1};

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  operand;
    logic [2:0]  bit_index;
    logic [15:0] base_word;
    logic [15:0] addend_word;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
  } out_word_t;

endpackage
`default_nettype wire

@@ sv/eight_bit_alu_with_flags.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Accumulator ALU with Z/N/H/C flags: 8-bit arithmetic and logic, rotates,
// shifts, bit operations, decimal adjust and the two 16-bit adds.
// ----------------------------------------------------------------------------
// Each input word carries one operation. It is captured in an input register,
// evaluated against the accumulator and flag registers, and the result lands
// in an output register while the accumulator and flags are updated in the
// same edge. A new word can be taken every cycle unless the input stalls, so
// the throughput is one word per clock. The output register decouples the
// sides: a word is still accepted while a finished result waits, and the
// input stalls only when both registers are full and the output is stalled.
// The accumulator resets to 0x01 and the flags to Z=1 N=0 H=1 C=1. Unused kind
// codes leave the state alone.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire ebalu_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output ebalu_pkg::out_word_t      out_data
);
  import ebalu_pkg::*;

  // Pipeline registers
  logic      in_v_r;
  in_word_t  in_d_r;
  logic      out_v_r;
  out_word_t out_d_r;

  // Architectural state
  logic [7:0] acc_r;
  flags_t     flags_r;

  // Datapath results
  logic [7:0]  rb;
  logic [15:0] rw;
  flags_t      f_nxt;
  logic        acc_we;
  logic        advance;

  // Arithmetic helpers
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  hsum;
  logic [8:0]  diff9;
  logic [4:0] hdiff;
  logic [16:0] sumw;
  logic [12:0] sumw_lo;
  logic [15:0] sp_ext;
  logic [4:0]  sp_h;
  logic [8:0]  sp_c;
  logic [7:0]  daa_t;
  logic        daa_c;
  logic [7:0]  bit_mask;
  logic [7:0]  v;

  // Move a word forward when it exists and the output slot is free or draining
  assign advance   = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && out_v_r && out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // Shared adders
  assign v        = in_d_r.operand;
  assign cin      = flags_r.c && (in_d_r.kind == KIND_ADC || in_d_r.kind == KIND_SBC);
  assign sum9     = {1'b0, acc_r} + {1'b0, v} + {8'd0, cin};
  assign hsum     = {1'b0, acc_r[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign diff9    = {1'b0, acc_r} - {1'b0, v} - {8'd0, cin};
  assign hdiff    = {1'b0, acc_r[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
  assign sumw     = {1'b0, in_d_r.base_word} + {1'b0, in_d_r.addend_word};
  assign sumw_lo  = {1'b0, in_d_r.base_word[11:0]} + {1'b0, in_d_r.addend_word[11:0]};
  assign sp_ext   = {{8{v[7]}}, v};
  assign sp_h     = {1'b0, in_d_r.base_word[3:0]} + {1'b0, v[3:0]};
  assign sp_c     = {1'b0, in_d_r.base_word[7:0]} + {1'b0, v};
  assign bit_mask = 8'd1 << in_d_r.bit_index;

  // Decimal adjust of the accumulator
  always_comb begin
    daa_t = acc_r;
    daa_c = flags_r.c;
    if (!flags_r.n) begin
      if (flags_r.c || acc_r > DAA_HI_LIM) begin
        daa_t = daa_t + DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (flags_r.h || daa_t[3:0] > DAA_LO_LIM) begin
        daa_t = daa_t + DAA_LO_ADJ;
      end
    end else begin
      if (flags_r.c) begin
        daa_t = daa_t - DAA_HI_ADJ;
      end
      if (flags_r.h) begin
        daa_t = daa_t - DAA_LO_ADJ;
      end
    end
  end

  // Decode the operation and pick the result and flags
  always_comb begin
    rb     = acc_r;
    rw     = '0;
    f_nxt  = flags_r;
    acc_we = 1'b0;
    unique case (in_d_r.kind) inside
      KIND_ADD, KIND_ADC: begin
        rb     = sum9[7:0];
        f_nxt  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum[4], c: sum9[8]};
        acc_we = 1'b1;
      end
      KIND_SUB, KIND_SBC: begin
        rb     = diff9[7:0];
        f_nxt  = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff[4], c: diff9[8]};
        acc_we = 1'b1;
      end
      KIND_CP: begin
        f_nxt = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff[4], c: diff9[8]};
      end
      KIND_AND: begin
        rb     = acc_r & v;
        f_nxt  = '{z: ((acc_r & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
        acc_we = 1'b1;
      end
      KIND_OR: begin
        rb     = acc_r | v;
        f_nxt  = '{z: ((acc_r | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        acc_we = 1'b1;
      end
      KIND_XOR: begin
        rb     = acc_r ^ v;
        f_nxt  = '{z: ((acc_r ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        acc_we = 1'b1;
      end
      KIND_INC: begin
        rb    = v + 8'd1;
        f_nxt = '{z: (v == 8'hFF), n: 1'b0, h: (v[3:0] == 4'hF), c: flags_r.c};
      end
      KIND_DEC: begin
        rb    = v - 8'd1;
        f_nxt = '{z: (v == 8'h01), n: 1'b1, h: (v[3:0] == 4'h0), c: flags_r.c};
      end
      KIND_DAA: begin
        rb     = daa_t;
        f_nxt  = '{z: (daa_t == 8'd0), n: flags_r.n, h: 1'b0, c: daa_c};
        acc_we = 1'b1;
      end
      KIND_CPL: begin
        rb     = ~acc_r;
        f_nxt  = '{z: flags_r.z, n: 1'b1, h: 1'b1, c: flags_r.c};
        acc_we = 1'b1;
      end
      KIND_CCF: begin
        f_nxt = '{z: flags_r.z, n: 1'b0, h: 1'b0, c: !flags_r.c};
      end
      KIND_SCF: begin
        f_nxt = '{z: flags_r.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      KIND_RLC: begin
        rb    = {v[6:0], v[7]};
        f_nxt = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      KIND_RL: begin
        rb    = {v[6:0], flags_r.c};
        f_nxt = '{z: ({v[6:0], flags_r.c} == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      KIND_RRC: begin
        rb    = {v[0], v[7:1]};
        f_nxt = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      KIND_RR: begin
        rb    = {flags_r.c, v[7:1]};
        f_nxt = '{z: ({flags_r.c, v[7:1]} == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      KIND_SLA: begin
        rb    = {v[6:0], 1'b0};
        f_nxt = '{z: (v[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      KIND_SRA: begin
        rb    = {v[7], v[7:1]};
        f_nxt = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      KIND_SRL: begin
        rb    = {1'b0, v[7:1]};
        f_nxt = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      KIND_SWAP: begin
        rb    = {v[3:0], v[7:4]};
        f_nxt = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      KIND_BIT: begin
        rb    = v;
        f_nxt = '{z: ((v & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags_r.c};
      end
      KIND_SET: begin
        rb = v | bit_mask;
      end
      KIND_RES: begin
        rb = v & ~bit_mask;
      end
      KIND_ADDW: begin
        rw    = sumw[15:0];
        f_nxt = '{z: flags_r.z, n: 1'b0, h: sumw_lo[12], c: sumw[16]};
      end
      KIND_ADDSP: begin
        rw    = in_d_r.base_word + sp_ext;
        f_nxt = '{z: 1'b0, n: 1'b0, h: sp_h[4], c: sp_c[8]};
      end
      default: begin
        // Unused codes: hold state, report accumulator and flags
        rb = acc_r;
      end
    endcase
  end

  // Control registers and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= ACC_RESET;
      flags_r <= FLAGS_RESET;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        flags_r <= f_nxt;
        if (acc_we) begin
          acc_r <= rb;
        end
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_d_r <= in_data;
    end
  end

  // Load the result word; hold it while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      out_d_r <= '{result_byte:     rb,
                   result_word:     rw,
                   zero_flag:       f_nxt.z,
                   subtract_flag:   f_nxt.n,
                   half_carry_flag: f_nxt.h,
                   carry_flag:      f_nxt.c};
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_eight_bit_alu_with_flags.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags
// Self-checking bench for the accumulator ALU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
// A shadow accumulator and flag register predict every result word as
// operations are accepted. Results are matched in order, field by field.
// Directed words cover the power-up state, every operation and its corner
// values. Decimal-adjust chains and random words follow, with random idle
// gaps on both sides and one long hold on the result side.
// ----------------------------------------------------------------------------
module tb_eight_bit_alu_with_flags;
  import ebalu_pkg::*;

  localparam int RANDOM_WORDS      = 900;
  localparam int DRAIN_HOLD_CYCLES = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  // Shadow state of the ALU and results still owed by it
  logic [7:0] shadow_acc;
  flags_t     shadow_flags;
  out_word_t  alu_expected[$];

  // Idle control shared by the sender, the receiver and the tests
  bit tx_gaps_on;
  bit rx_gaps_on;
  bit rx_hold_req;

  int fail_count;
  int words_sent;
  int results_checked;
  int bcd_chains;
  int input_held_cycles;

  eight_bit_alu_with_flags u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Compute the result of one operation and advance the shadow state.
  // Flags are packed as {Z, N, H, C}.
  function automatic out_word_t predict_alu_result(in_word_t w);
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  rb;
    logic [7:0]  adj;
    logic [15:0] rw;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        cin;
    logic        c;
    flags_t      f;
    out_word_t   r;
    a   = shadow_acc;
    v   = w.operand;
    f   = shadow_flags;
    cin = f.c;
    rb  = a;
    rw  = 16'h0000;
    case (w.kind)
      KIND_ADD, KIND_ADC: begin
        c    = (w.kind == KIND_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + {8'd0, c};
        nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
        rb   = sum9[7:0];
        f    = {rb == 8'h00, 1'b0, nib[4], sum9[8]};
        shadow_acc = rb;
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        // borrow shows up as the sign bit of the wider difference
        c    = (w.kind == KIND_SBC) ? cin : 1'b0;
        sum9 = {1'b0, a} - {1'b0, v} - {8'd0, c};
        nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
        f    = {sum9[7:0] == 8'h00, 1'b1, nib[4], sum9[8]};
        if (w.kind != KIND_CP) begin
          rb = sum9[7:0];
          shadow_acc = rb;
        end
      end
      KIND_AND: begin
        rb = a & v;
        f  = {rb == 8'h00, 1'b0, 1'b1, 1'b0};
        shadow_acc = rb;
      end
      KIND_OR: begin
        rb = a | v;
        f  = {rb == 8'h00, 1'b0, 1'b0, 1'b0};
        shadow_acc = rb;
      end
      KIND_XOR: begin
        rb = a ^ v;
        f  = {rb == 8'h00, 1'b0, 1'b0, 1'b0};
        shadow_acc = rb;
      end
      KIND_INC: begin
        rb = v + 8'h01;
        f  = {rb == 8'h00, 1'b0, v[3:0] == 4'hF, f.c};
      end
      KIND_DEC: begin
        rb = v - 8'h01;
        f  = {rb == 8'h00, 1'b1, v[3:0] == 4'h0, f.c};
      end
      KIND_DAA: begin
        adj = a;
        c   = f.c;
        if (!f.n) begin
          if (f.c || a > 8'h99) begin
            adj = adj + 8'h60;
            c   = 1'b1;
          end
          if (f.h || adj[3:0] > 4'd9) adj = adj + 8'h06;
        end else begin
          if (f.c) adj = adj - 8'h60;
          if (f.h) adj = adj - 8'h06;
        end
        rb = adj;
        f  = {rb == 8'h00, f.n, 1'b0, c};
        shadow_acc = rb;
      end
      KIND_CPL: begin
        rb = ~a;
        f  = {f.z, 1'b1, 1'b1, f.c};
        shadow_acc = rb;
      end
      KIND_CCF: f = {f.z, 1'b0, 1'b0, !f.c};
      KIND_SCF: f = {f.z, 1'b0, 1'b0, 1'b1};
      KIND_RLC: begin
        rb = {v[6:0], v[7]};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[7]};
      end
      KIND_RL: begin
        rb = {v[6:0], cin};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[7]};
      end
      KIND_RRC: begin
        rb = {v[0], v[7:1]};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[0]};
      end
      KIND_RR: begin
        rb = {cin, v[7:1]};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[0]};
      end
      KIND_SLA: begin
        rb = {v[6:0], 1'b0};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[7]};
      end
      KIND_SRA: begin
        rb = {v[7], v[7:1]};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[0]};
      end
      KIND_SRL: begin
        rb = {1'b0, v[7:1]};
        f  = {rb == 8'h00, 1'b0, 1'b0, v[0]};
      end
      KIND_SWAP: begin
        rb = {v[3:0], v[7:4]};
        f  = {rb == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      KIND_BIT: begin
        rb = v;
        f  = {!v[w.bit_index], 1'b0, 1'b1, f.c};
      end
      KIND_SET: rb = v | (8'h01 << w.bit_index);
      KIND_RES: rb = v & ~(8'h01 << w.bit_index);
      KIND_ADDW: begin
        sum17 = {1'b0, w.base_word} + {1'b0, w.addend_word};
        sum13 = {1'b0, w.base_word[11:0]} + {1'b0, w.addend_word[11:0]};
        rw    = sum17[15:0];
        f     = {f.z, 1'b0, sum13[12], sum17[16]};
      end
      KIND_ADDSP: begin
        // flags come from the unsigned low-byte add, the operand is sign-extended for the sum
        rw   = w.base_word + {{8{v[7]}}, v};
        nib  = {1'b0, w.base_word[3:0]} + {1'b0, v[3:0]};
        sum9 = {1'b0, w.base_word[7:0]} + {1'b0, v};
        f    = {1'b0, 1'b0, nib[4], sum9[8]};
      end
      default: ;
    endcase
    shadow_flags      = f;
    r.result_byte     = rb;
    r.result_word     = rw;
    r.zero_flag       = f.z;
    r.subtract_flag   = f.n;
    r.half_carry_flag = f.h;
    r.carry_flag      = f.c;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] expv, logic [15:0] gotv);
    if (expv !== gotv) begin
      $error("%s: expected %h, got %h", name, expv, gotv);
      fail_count++;
    end
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int gap_cycles(bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_word_t alu_word(logic [4:0] kind, logic [7:0] operand,
                                        logic [2:0] bit_index = 3'd0,
                                        logic [15:0] base_word = 16'h0000,
                                        logic [15:0] addend_word = 16'h0000);
    in_word_t w;
    w.kind        = kind;
    w.operand     = operand;
    w.bit_index   = bit_index;
    w.base_word   = base_word;
    w.addend_word = addend_word;
    return w;
  endfunction

  function automatic logic [7:0] corner_byte();
    logic [7:0] corners [8];
    corners = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] bcd_byte();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    return {hi, lo};
  endfunction

  function automatic in_word_t random_alu_word();
    in_word_t w;
    if ($urandom_range(0, 99) < 4) w.kind = 5'($urandom_range(27, 31));
    else w.kind = 5'($urandom_range(0, 26));
    w.operand     = corner_byte();
    w.bit_index   = 3'($urandom);
    w.base_word   = $urandom_range(0, 7) == 0 ? {corner_byte(), corner_byte()}
                                              : 16'($urandom);
    w.addend_word = 16'($urandom);
    return w;
  endfunction

  // Offer one word after a random gap and hold it until it is taken
  task automatic send_word(in_word_t w);
    repeat (gap_cycles(tx_gaps_on)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Load a BCD value, add or subtract another, then decimal adjust
  task automatic send_bcd_chain();
    logic [4:0] ops [4];
    ops = '{KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBC};
    send_word(alu_word(KIND_AND, 8'h00));
    send_word(alu_word(KIND_OR, bcd_byte()));
    send_word(alu_word(ops[$urandom_range(0, 3)], bcd_byte()));
    send_word(alu_word(KIND_DAA, 8'($urandom)));
    bcd_chains++;
  endtask

  // Track acceptance on both channels and match results in order
  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst_n) begin
      if (in_valid && in_stall) input_held_cycles++;
      if (in_valid && !in_stall) alu_expected.push_back(predict_alu_result(in_data));
      if (out_valid && !out_stall) begin
        if (alu_expected.size() == 0) begin
          $error("unexpected result word %h", out_data);
          fail_count++;
        end else begin
          exp_word = alu_expected.pop_front();
          check_field("result_byte", {8'h00, exp_word.result_byte},
                      {8'h00, out_data.result_byte});
          check_field("result_word", exp_word.result_word, out_data.result_word);
          check_field("zero_flag", {15'd0, exp_word.zero_flag},
                      {15'd0, out_data.zero_flag});
          check_field("subtract_flag", {15'd0, exp_word.subtract_flag},
                      {15'd0, out_data.subtract_flag});
          check_field("half_carry_flag", {15'd0, exp_word.half_carry_flag},
                      {15'd0, out_data.half_carry_flag});
          check_field("carry_flag", {15'd0, exp_word.carry_flag},
                      {15'd0, out_data.carry_flag});
          results_checked++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold when a test asks for one
  initial begin : result_drain
    int run_left;
    int stall_left;
    out_stall  = 1'b0;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = DRAIN_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = gap_cycles(rx_gaps_on);
        run_left   = $urandom_range(0, 12);
      end
    end
  end

  task automatic test_power_up_state();
    // decimal adjust reads N, H and C straight from reset, then carry-in
    send_word(alu_word(KIND_DAA, 8'h00));
    send_word(alu_word(KIND_ADC, 8'h00));
  endtask

  task automatic test_arith_logic();
    send_word(alu_word(KIND_ADD, 8'hFF));
    send_word(alu_word(KIND_ADC, 8'hFF));
    send_word(alu_word(KIND_SUB, 8'hFF));
    send_word(alu_word(KIND_SBC, 8'h80));
    send_word(alu_word(KIND_CP, 8'h00));
    send_word(alu_word(KIND_AND, 8'h00));
    send_word(alu_word(KIND_OR, 8'hFF));
    send_word(alu_word(KIND_XOR, 8'hFF));
  endtask

  task automatic test_inc_dec_daa();
    send_word(alu_word(KIND_INC, 8'hFF));
    send_word(alu_word(KIND_DEC, 8'h00));
    // decimal adjust after a subtract takes the N=1 path
    send_word(alu_word(KIND_SUB, 8'h01));
    send_word(alu_word(KIND_DAA, 8'h00));
  endtask

  task automatic test_flag_ops();
    send_word(alu_word(KIND_CPL, 8'h00));
    send_word(alu_word(KIND_CCF, 8'h00));
    send_word(alu_word(KIND_SCF, 8'h00));
  endtask

  task automatic test_rotate_shift();
    send_word(alu_word(KIND_RLC, 8'h80));
    send_word(alu_word(KIND_RL, 8'h80));
    send_word(alu_word(KIND_RRC, 8'h01));
    send_word(alu_word(KIND_RR, 8'h01));
    send_word(alu_word(KIND_SLA, 8'h80));
    send_word(alu_word(KIND_SRA, 8'h81));
    send_word(alu_word(KIND_SRL, 8'h01));
    send_word(alu_word(KIND_SWAP, 8'hF0));
  endtask

  task automatic test_bit_ops();
    send_word(alu_word(KIND_BIT, 8'h80, 3'd7));
    send_word(alu_word(KIND_BIT, 8'hFE, 3'd0));
    send_word(alu_word(KIND_SET, 8'h00, 3'd7));
    send_word(alu_word(KIND_RES, 8'hFF, 3'd0));
  endtask

  task automatic test_word_adds();
    send_word(alu_word(KIND_ADDW, 8'h00, 3'd0, 16'hFFFF, 16'h0001));
    send_word(alu_word(KIND_ADDSP, 8'h01, 3'd0, 16'hFFFF));
    send_word(alu_word(KIND_ADDSP, 8'h80, 3'd0, 16'h0000));
  endtask

  task automatic test_unused_kinds();
    send_word(alu_word(5'd31, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF));
  endtask

  // Hold the result side long enough that the input stalls too
  task automatic test_backpressure();
    tx_gaps_on  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (40) send_word(random_alu_word());
    tx_gaps_on  = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      // one phase with no idling at all, one with a busy sender only
      tx_gaps_on = (phase != 1) && (phase != 2);
      rx_gaps_on = (phase != 1);
      target = words_sent + RANDOM_WORDS / 4;
      while (words_sent < target) begin
        if ($urandom_range(0, 99) < 20) send_bcd_chain();
        else send_word(random_alu_word());
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    tx_gaps_on   = 1'b1;
    rx_gaps_on   = 1'b1;
    rx_hold_req  = 1'b0;
    shadow_acc   = ACC_RESET;
    shadow_flags = FLAGS_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_power_up_state();
    test_arith_logic();
    test_inc_dec_daa();
    test_flag_ops();
    test_rotate_shift();
    test_bit_ops();
    test_word_adds();
    test_unused_kinds();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (alu_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d words with %0d decimal-adjust chains; %0d results checked.",
             words_sent, bcd_chains, results_checked);
    $display("Input was held off on %0d cycles.", input_held_cycles);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
